/* rtl/core/sxf_pkg.sv */
package sxf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SumW    = 7;
  localparam int unsigned PosW    = 4;
  localparam int unsigned ReqW    = 7 * ByteW;
  localparam int unsigned CfgIdxW = 2;

  // fixed message bytes
  localparam logic [ByteW-1:0] SxStart  = 8'hF0;
  localparam logic [ByteW-1:0] SxMaker  = 8'h41;
  localparam logic [ByteW-1:0] SxCmdReq = 8'h11;
  localparam logic [ByteW-1:0] SxCmdSet = 8'h12;
  localparam logic [ByteW-1:0] SxEnd    = 8'hF7;

  // request kinds
  localparam logic KindRequest = 1'b0;
  localparam logic KindSet     = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxDevice = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxModel  = 2'd1;

  localparam logic [ByteW-1:0] DeviceIdReset = 8'd16;
  localparam logic [ByteW-1:0] ModelIdReset  = 8'd0;

  // byte positions within a message
  localparam logic [PosW-1:0] PosStart  = 4'd0;
  localparam logic [PosW-1:0] PosMaker  = 4'd1;
  localparam logic [PosW-1:0] PosDevice = 4'd2;
  localparam logic [PosW-1:0] PosModel  = 4'd3;
  localparam logic [PosW-1:0] PosCmd    = 4'd4;
  // position of the checksum byte, one past the payload
  localparam logic [PosW-1:0] PosChkReq = 4'd11;
  localparam logic [PosW-1:0] PosChkSet = 4'd9;

  typedef struct packed {
    logic load;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

/* rtl/core/sysex_request_and_data_set_framer_unit.sv */
// latency: first message byte is offered the cycle after the request is accepted
// a data request gives 13 bytes and a parameter change 11, one per cycle while the sink is ready
// a new request is taken only once the end byte of the current message has been sent
// and the state machine is back in idle
// reset: state machine idle, device id 16, model id 0
module sysex_request_and_data_set_framer_unit
  import sxf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // addr_high, addr_mid, addr_low, size_high, size_mid, size_low, param_value
  input  logic [ReqW-1:0]    s_axis_tdata_i,
  // kind
  input  logic               s_axis_tuser_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // msg_byte
  output logic [ByteW-1:0]   m_axis_tdata_o,
  output logic               m_axis_tlast_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [ReqW-1:0] req;

  assign cfg_ready_o = 1'b1;

  // held order, first byte sent on top; unused payload fields dropped
  assign req = (s_axis_tuser_i == KindSet) ?
    {s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tdata_i[23:16],
     s_axis_tdata_i[55:48], 24'd0} :
    {s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tdata_i[23:16],
     s_axis_tdata_i[31:24], s_axis_tdata_i[39:32], s_axis_tdata_i[47:40], 8'd0};

  sxf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sxf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .kind_i      (s_axis_tuser_i),
    .req_i       (req),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .msg_byte_o  (m_axis_tdata_o),
    .last_o      (m_axis_tlast_o)
  );

endmodule

/* rtl/core/sxf_ctrl.sv */
module sxf_ctrl
  import sxf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StBusy = 1'b1;

  logic state_q, state_d;
  logic in_fire, out_fire;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StBusy);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_fire    = out_valid_o & out_ready_i;

  assign cmd_o.load    = in_fire;
  assign cmd_o.advance = out_fire;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_fire) state_d = StBusy;
      end
      StBusy: begin
        if (out_fire && status_i.last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output sides open together");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted request did not start a message");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && status_i.last) |=> in_ready_o)
    else $error("message did not close after last byte");

  a_busy_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_fire) |=> out_valid_o)
    else $error("message dropped while stalled");

endmodule

/* rtl/core/sxf_datapath.sv */
module sxf_datapath
  import sxf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  logic               kind_i,
  input  logic [ReqW-1:0]    req_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  output logic [ByteW-1:0]   msg_byte_o,
  output logic               last_o
);

  logic [ByteW-1:0] device_q, model_q;
  logic [ReqW-1:0]  held_q;
  logic [SumW-1:0]  sum_q;
  logic [PosW-1:0]  pos_q;
  logic             kind_q;
  logic [PosW-1:0]  pos_chk;
  logic [SumW-1:0]  chk;
  logic             is_payload;
  logic [ByteW-1:0] top_byte;

  assign pos_chk  = (kind_q == KindSet) ? PosChkSet : PosChkReq;
  assign chk      = 7'd0 - sum_q;
  assign top_byte = held_q[ReqW-1 -: ByteW];

  always_comb begin
    msg_byte_o = SxEnd;
    last_o     = 1'b0;
    is_payload = 1'b0;
    case (pos_q)
      PosStart:  msg_byte_o = SxStart;
      PosMaker:  msg_byte_o = SxMaker;
      PosDevice: msg_byte_o = device_q;
      PosModel:  msg_byte_o = model_q;
      PosCmd:    msg_byte_o = (kind_q == KindSet) ? SxCmdSet : SxCmdReq;
      default: begin
        if (pos_q < pos_chk) begin
          msg_byte_o = top_byte;
          is_payload = 1'b1;
        end else if (pos_q == pos_chk) begin
          msg_byte_o = {1'b0, chk};
        end else begin
          msg_byte_o = SxEnd;
          last_o     = 1'b1;
        end
      end
    endcase
  end

  assign status_o.last = last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_q <= DeviceIdReset;
      model_q  <= ModelIdReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgIdxDevice) device_q <= cfg_data_i;
      if (cfg_index_i == CfgIdxModel)  model_q  <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      kind_q <= KindRequest;
    end else if (cmd_i.load) begin
      pos_q  <= '0;
      sum_q  <= '0;
      kind_q <= kind_i;
    end else if (cmd_i.advance) begin
      pos_q <= last_o ? '0 : pos_q + 4'd1;
      if (is_payload) sum_q <= sum_q + top_byte[SumW-1:0];
    end
  end

  // payload bytes leave from the top of the shift register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      held_q <= req_i;
    end else if (cmd_i.advance && is_payload) begin
      held_q <= {held_q[ReqW-ByteW-1:0], {ByteW{1'b0}}};
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosChkReq + 4'd1)
    else $error("byte position beyond message end");

  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (pos_q == PosStart && sum_q == '0))
    else $error("load did not clear position and sum");

  a_byte_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_i.load && !cmd_i.advance && !cfg_we_i) |=> $stable(msg_byte_o))
    else $error("output byte changed without a transaction");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import sxf_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned MaxPrinted    = 20;
  // indexes past the register list, writes to them change nothing
  localparam logic [CfgIdxW-1:0] CfgIdxSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareB = 2'd3;

  // first member lands in the top bits, so addr_high sits at bit 0
  typedef struct packed {
    logic [ByteW-1:0] param_value;
    logic [ByteW-1:0] size_low;
    logic [ByteW-1:0] size_mid;
    logic [ByteW-1:0] size_high;
    logic [ByteW-1:0] addr_low;
    logic [ByteW-1:0] addr_mid;
    logic [ByteW-1:0] addr_high;
  } sysex_req_t;

  typedef struct packed {
    logic [ByteW-1:0] msg_byte;
    logic             last;
  } sysex_byte_t;

  class sysex_frame_scoreboard;
    logic [ByteW-1:0] device_id;
    logic [ByteW-1:0] model_id;
    sysex_byte_t      pending_bytes[$];
    int unsigned      errors;

    function new();
      device_id = DeviceIdReset;
      model_id  = ModelIdReset;
      errors    = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] value);
      if (idx == CfgIdxDevice) begin
        device_id = value;
      end else if (idx == CfgIdxModel) begin
        model_id = value;
      end
    endfunction

    function void push_byte(logic [ByteW-1:0] b, logic last);
      sysex_byte_t e;
      e.msg_byte = b;
      e.last     = last;
      pending_bytes = {pending_bytes, e};
    endfunction

    // frames one request into the bytes the block should send
    function void note_request(logic kind, sysex_req_t req);
      logic [ByteW-1:0] payload[6];
      int unsigned      n;
      logic [SumW-1:0]  sum;
      payload[0] = req.addr_high;
      payload[1] = req.addr_mid;
      payload[2] = req.addr_low;
      if (kind == KindSet) begin
        payload[3] = req.param_value;
        n = 4;
      end else begin
        payload[3] = req.size_high;
        payload[4] = req.size_mid;
        payload[5] = req.size_low;
        n = 6;
      end
      push_byte(SxStart, 1'b0);
      push_byte(SxMaker, 1'b0);
      push_byte(device_id, 1'b0);
      push_byte(model_id, 1'b0);
      push_byte((kind == KindSet) ? SxCmdSet : SxCmdReq, 1'b0);
      sum = '0;
      for (int unsigned i = 0; i < n; i++) begin
        sum += payload[i][SumW-1:0];
        push_byte(payload[i], 1'b0);
      end
      // two's complement in 7 bits is (128 - sum) mod 128
      push_byte({1'b0, SumW'(-sum)}, 1'b0);
      push_byte(SxEnd, 1'b1);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxPrinted) begin
        $display("[%0t] error: %s", $time, msg);
      end
    endtask

    task check_byte(logic [ByteW-1:0] b, logic last);
      sysex_byte_t e;
      if (pending_bytes.size() == 0) begin
        report($sformatf("byte %h last %b with nothing outstanding", b, last));
      end else begin
        e = pending_bytes.pop_front();
        if (b !== e.msg_byte) begin
          report($sformatf("msg_byte %h, wanted %h", b, e.msg_byte));
        end
        if (last !== e.last) begin
          report($sformatf("last %b on byte %h, wanted %b", last, b, e.last));
        end
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [ReqW-1:0]    s_axis_tdata_i;
  logic               s_axis_tuser_i;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [ByteW-1:0]   m_axis_tdata_o;
  logic               m_axis_tlast_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ByteW-1:0]   cfg_data_i;

  sysex_frame_scoreboard sb = new();

  logic        src_idle;
  logic        sink_idle;
  int unsigned stall_cycles;

  sysex_request_and_data_set_framer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // request transactions are noted before bytes are checked in the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        sb.note_request(s_axis_tuser_i, sysex_req_t'(s_axis_tdata_i));
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_byte(m_axis_tdata_o, m_axis_tlast_o);
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    wait (stall_cycles >= WatchdogLimit);
    $display("end of test: mismatches");
    $finish;
  end

  // byte sink: random back-pressure before each byte while sink_idle is set
  initial begin
    int unsigned gap;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      gap = sink_idle ? $urandom_range(0, 16) : 0;
      if (gap != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  function automatic logic [ByteW-1:0] pick_byte();
    logic [ByteW-1:0] corners[4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 7) == 0) begin
      return corners[$urandom_range(0, 3)];
    end
    return ByteW'($urandom_range(0, 255));
  endfunction

  function automatic sysex_req_t random_request();
    sysex_req_t r;
    r.addr_high   = pick_byte();
    r.addr_mid    = pick_byte();
    r.addr_low    = pick_byte();
    r.size_high   = pick_byte();
    r.size_mid    = pick_byte();
    r.size_low    = pick_byte();
    r.param_value = pick_byte();
    return r;
  endfunction

  // leaves tvalid high so a back-to-back request needs no second assignment
  task automatic send_request(logic kind, sysex_req_t req);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ReqW'(req);
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // one edge first so the last request transaction is already noted
  task automatic drain_frames();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, value);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    sysex_req_t req;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= KindRequest;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CfgIdxDevice;
    cfg_data_i      <= '0;
    src_idle        <= 1'b1;
    sink_idle       <= 1'b1;
    stall_cycles    <= 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed requests under reset register values
    req = '0;
    send_request(KindRequest, req);
    send_request(KindSet, req);
    req = '1;
    send_request(KindRequest, req);
    send_request(KindSet, req);
    // unused payload fields carry junk
    req = '{param_value: 8'hA5, size_low: 8'h00, size_mid: 8'h00, size_high: 8'h00,
            addr_low: 8'h01, addr_mid: 8'h02, addr_high: 8'h03};
    send_request(KindRequest, req);
    req = '{param_value: 8'h00, size_low: 8'hFF, size_mid: 8'h5A, size_high: 8'hC3,
            addr_low: 8'h10, addr_mid: 8'h20, addr_high: 8'h30};
    send_request(KindSet, req);
    // sum a multiple of 128, checksum zero
    req = '{param_value: 8'h00, size_low: 8'h00, size_mid: 8'h00, size_high: 8'h00,
            addr_low: 8'h00, addr_mid: 8'h00, addr_high: 8'h80};
    send_request(KindRequest, req);
    req = '{param_value: 8'h40, size_low: 8'h00, size_mid: 8'h00, size_high: 8'h00,
            addr_low: 8'h20, addr_mid: 8'h10, addr_high: 8'h10};
    send_request(KindSet, req);
    // high bytes, checksum wraps
    req = '{param_value: 8'h81, size_low: 8'h80, size_mid: 8'h7F, size_high: 8'hFE,
            addr_low: 8'h80, addr_mid: 8'hFF, addr_high: 8'h81};
    send_request(KindRequest, req);
    send_request(KindSet, req);
    drain_frames();

    // extreme ids, plus writes past the register list that must change nothing
    write_cfg(CfgIdxDevice, 8'h00);
    write_cfg(CfgIdxModel, 8'hFF);
    write_cfg(CfgIdxSpareA, ByteW'($urandom_range(0, 255)));
    write_cfg(CfgIdxSpareB, ByteW'($urandom_range(0, 255)));
    src_idle  <= 1'b0;
    sink_idle <= 1'b0;
    req = '1;
    send_request(KindSet, req);
    send_request(KindRequest, req);
    req = '0;
    send_request(KindSet, req);
    send_request(KindRequest, req);
    drain_frames();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_cfg(CfgIdxDevice, 8'hFF);
          write_cfg(CfgIdxModel, 8'h00);
        end
        1: begin
          write_cfg(CfgIdxDevice, 8'h7F);
          write_cfg(CfgIdxModel, 8'h80);
        end
        default: begin
          write_cfg(CfgIdxDevice, pick_byte());
          write_cfg(CfgIdxModel, pick_byte());
          write_cfg(($urandom_range(0, 1) == 0) ? CfgIdxSpareA : CfgIdxSpareB, pick_byte());
        end
      endcase
      src_idle  <= (phase != 2) && (phase != 3);
      sink_idle <= (phase != 2) && (phase != 4);
      for (int i = 0; i < 58; i++) begin
        send_request(($urandom_range(0, 1) == 0) ? KindRequest : KindSet, random_request());
      end
      drain_frames();
    end

    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
